/* rtl/gbfp_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the binary GNSS frame parser.
// No dependencies.
package gbfp_pkg;

  localparam logic [7:0]  SyncFirst     = 8'hB5;
  localparam logic [7:0]  SyncSecond    = 8'h62;
  localparam logic [7:0]  ClassNav      = 8'h01;
  localparam logic [7:0]  IdLeap        = 8'h26;
  localparam logic [7:0]  ClassMon      = 8'h0A;
  localparam logic [7:0]  IdVersion     = 8'h04;
  localparam logic [15:0] LeapMinLen    = 16'd24;
  localparam logic [15:0] VersionMinLen = 16'd40;
  localparam logic [15:0] IdxSource     = 16'd8;
  localparam logic [15:0] IdxLeap       = 16'd9;
  localparam logic [15:0] IdxFlags      = 16'd23;

  typedef enum logic [3:0] {
    PH_SYNC1   = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_CLASS   = 4'd2,
    PH_IDENT   = 4'd3,
    PH_LEN_LO  = 4'd4,
    PH_LEN_HI  = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CK_A    = 4'd7,
    PH_CK_B    = 4'd8
  } phase_e;

  typedef struct packed {
    logic [7:0]        class_code;
    logic [7:0]        msg_ident;
    logic [15:0]       payload_length;
    logic              is_leap_message;
    logic              is_version_message;
    logic [7:0]        leap_source;
    logic signed [7:0] leap_seconds;
    logic              leap_seconds_valid;
  } result_t;

endpackage

/* rtl/gbfp_in_stage.sv */
`timescale 1ns / 1ps
// Input register for received bytes; holds one item until the deframer takes it.
// Depends on nothing.
module gbfp_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       take_i,
  output logic       byte_valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;

  // accept while empty or while the held item leaves this cycle
  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
      byte_d  = rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_valid_o = valid_q;
  assign byte_o       = byte_q;

endmodule

/* rtl/gbfp_deframer.sv */
`timescale 1ns / 1ps
// Byte-wise frame state machine with payload capture and leap-second store.
// Depends on gbfp_pkg.
module gbfp_deframer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  output logic             res_valid_o,
  output gbfp_pkg::result_t res_o
);
  import gbfp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  class_q, class_d;
  logic [7:0]  ident_q, ident_d;
  logic [15:0] length_q, length_d;
  logic [15:0] count_q, count_d;
  logic [7:0]  source_q, source_d;
  logic [7:0]  leap_q, leap_d;
  logic [7:0]  flags_q, flags_d;
  logic [7:0]  stored_leap_q, stored_leap_d;
  logic        stored_valid_q, stored_valid_d;
  logic [15:0] full_len;
  logic [15:0] count_inc;
  logic        is_leap;
  logic        is_ver;

  assign full_len  = {byte_i, length_q[7:0]};
  assign count_inc = count_q + 16'd1;
  assign is_leap   = (class_q == ClassNav) && (ident_q == IdLeap) && (length_q >= LeapMinLen);
  assign is_ver    = (class_q == ClassMon) && (ident_q == IdVersion) &&
                     (length_q >= VersionMinLen);

  always_comb begin
    phase_d        = phase_q;
    class_d        = class_q;
    ident_d        = ident_q;
    length_d       = length_q;
    count_d        = count_q;
    source_d       = source_q;
    leap_d         = leap_q;
    flags_d        = flags_q;
    stored_leap_d  = stored_leap_q;
    stored_valid_d = stored_valid_q;
    res_valid_o    = 1'b0;
    if (step_i) begin
      unique case (phase_q)
        PH_SYNC1: if (byte_i == SyncFirst) phase_d = PH_SYNC2;
        PH_SYNC2: phase_d = (byte_i == SyncSecond) ? PH_CLASS : PH_SYNC1;
        PH_CLASS: begin
          class_d = byte_i;
          phase_d = PH_IDENT;
        end
        PH_IDENT: begin
          ident_d = byte_i;
          phase_d = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          length_d = {8'd0, byte_i};
          phase_d  = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          length_d = full_len;
          count_d  = '0;
          phase_d  = (full_len != '0) ? PH_PAYLOAD : PH_CK_A;
        end
        PH_PAYLOAD: begin
          if (count_q == IdxSource) source_d = byte_i;
          else if (count_q == IdxLeap) leap_d = byte_i;
          else if (count_q == IdxFlags) flags_d = byte_i;
          count_d = count_inc;
          if (count_inc >= length_q) phase_d = PH_CK_A;
        end
        PH_CK_A: phase_d = PH_CK_B;
        PH_CK_B: begin
          if (is_leap) begin
            stored_leap_d  = leap_q;
            stored_valid_d = flags_q[0];
          end
          res_valid_o = 1'b1;
          phase_d     = PH_SYNC1;
        end
        default: phase_d = PH_SYNC1;
      endcase
    end
  end

  always_comb begin
    res_o.class_code         = class_q;
    res_o.msg_ident          = ident_q;
    res_o.payload_length     = length_q;
    res_o.is_leap_message    = is_leap;
    res_o.is_version_message = is_ver;
    res_o.leap_source        = is_leap ? source_q : 8'd0;
    res_o.leap_seconds       = stored_leap_d;
    res_o.leap_seconds_valid = stored_valid_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_SYNC1;
      class_q        <= '0;
      ident_q        <= '0;
      length_q       <= '0;
      count_q        <= '0;
      source_q       <= '0;
      leap_q         <= '0;
      flags_q        <= '0;
      stored_leap_q  <= '0;
      stored_valid_q <= 1'b0;
    end else begin
      phase_q        <= phase_d;
      class_q        <= class_d;
      ident_q        <= ident_d;
      length_q       <= length_d;
      count_q        <= count_d;
      source_q       <= source_d;
      leap_q         <= leap_d;
      flags_q        <= flags_d;
      stored_leap_q  <= stored_leap_d;
      stored_valid_q <= stored_valid_d;
    end
  end

endmodule

/* rtl/gbfp_out_stage.sv */
`timescale 1ns / 1ps
// Result register; holds a finished frame report until the consumer takes it.
// Depends on gbfp_pkg.
module gbfp_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  gbfp_pkg::result_t res_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output gbfp_pkg::result_t res_o
);
  import gbfp_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q, res_d;

  // slot is free when empty or drained this cycle
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (free_o) begin
      valid_d = load_i;
      res_d   = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

/* rtl/gbfp_top_unused_guard.sv */
`timescale 1ns / 1ps
// Advance gate: lets the held byte into the deframer when the result slot can take it.
// Depends on nothing.
module gbfp_step_gate (
  input  logic byte_valid_i,
  input  logic slot_free_i,
  output logic step_o
);

  assign step_o = byte_valid_i && slot_free_i;

endmodule

/* rtl/gnss_binary_frame_parser.sv */
`timescale 1ns / 1ps
// Top level of the binary GNSS frame parser: input register, deframer, result register.
// Depends on gbfp_pkg, gbfp_in_stage, gbfp_step_gate, gbfp_deframer, gbfp_out_stage.
//
//   Port group   Direction  Handshake                 Carries
//   rx byte      in         in_valid_i / in_ready_o   rx_byte_i, one received byte
//   frame report out        out_valid_o / out_ready_i class, id, length, type flags, leap info
//
// One byte per cycle sustained while the result register can take a report: a byte
// is registered in the input register, then the deframer advances its state on it
// and, on the last checksum byte, loads the frame report into the result register.
// Reset clears the frame phase, captures and the stored leap-second values.
// A stalled report holds the held byte back; bytes keep flowing while the
// report register drains in the same cycle.
module gnss_binary_frame_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        rx_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        class_code_o,
  output logic [7:0]        msg_ident_o,
  output logic [15:0]       payload_length_o,
  output logic              is_leap_message_o,
  output logic              is_version_message_o,
  output logic [7:0]        leap_source_o,
  output logic signed [7:0] leap_seconds_o,
  output logic              leap_seconds_valid_o
);
  import gbfp_pkg::*;

  logic       byte_valid;
  logic [7:0] held_byte;
  logic       slot_free;
  logic       step;
  logic       res_valid;
  result_t    res_next;
  result_t    res_out;

  // hold the incoming byte until the deframer can advance on it
  gbfp_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .take_i      (step),
    .byte_valid_o(byte_valid),
    .byte_o      (held_byte)
  );

  // advance only when a possible report has somewhere to go
  gbfp_step_gate u_gate (
    .byte_valid_i(byte_valid),
    .slot_free_i (slot_free),
    .step_o      (step)
  );

  gbfp_deframer u_deframer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .byte_i     (held_byte),
    .res_valid_o(res_valid),
    .res_o      (res_next)
  );

  gbfp_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (res_valid),
    .res_i      (res_next),
    .free_o     (slot_free),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .res_o      (res_out)
  );

  assign class_code_o         = res_out.class_code;
  assign msg_ident_o          = res_out.msg_ident;
  assign payload_length_o     = res_out.payload_length;
  assign is_leap_message_o    = res_out.is_leap_message;
  assign is_version_message_o = res_out.is_version_message;
  assign leap_source_o        = res_out.leap_source;
  assign leap_seconds_o       = res_out.leap_seconds;
  assign leap_seconds_valid_o = res_out.leap_seconds_valid;

endmodule
